@@ rtl/drs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drs_pkg
// Shared types and fixed constants of the replacement policy block.
// ----------------------------------------------------------------------------
package drs_pkg;

  localparam logic REQ_VICTIM = 1'b0;
  localparam logic REQ_UPDATE = 1'b1;

  localparam logic [1:0] LEAD_NONE  = 2'd0;
  localparam logic [1:0] LEAD_SRRIP = 2'd1;
  localparam logic [1:0] LEAD_BRRIP = 2'd2;

  localparam logic REG_HOT  = 1'b0;
  localparam logic REG_DUEL = 1'b1;

  localparam logic [1:0] RRPV_MAX   = 2'd3;
  localparam logic [1:0] RRPV_SRRIP = 2'd2;
  localparam logic [1:0] RRPV_NEAR  = 2'd0;
  localparam logic [2:0] SIG_MAX    = 3'd7;
  localparam logic [2:0] SIG_RESET  = 3'd4;
  localparam logic [1:0] CONF_MAX   = 2'd3;
  localparam logic [9:0] SEL_MAX    = 10'd1023;
  localparam logic [9:0] SEL_RESET  = 10'd511;
  localparam logic [2:0] HOT_RESET  = 3'd5;
  localparam logic [9:0] DUEL_RESET = 10'd511;

  localparam int HASH_W    = 16;
  localparam int BIMODAL_W = 5;

  typedef struct packed {
    logic              req_type;
    logic [10:0]       set_index;
    logic [3:0]        way;
    logic [HASH_W-1:0] hash;
    logic [31:0]       blk;
    logic              hit;
    logic [1:0]        lead;
  } drs_entry_t;

  typedef struct packed {
    logic [2:0] hot_threshold;
    logic [9:0] duel_threshold;
  } drs_cfg_t;

endpackage

@@ rtl/drs_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drs_in_if
// Request channel: valid/ready handshake with the access item.
// ----------------------------------------------------------------------------
interface drs_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [10:0] set_index;
  logic [3:0]  way;
  logic [63:0] pc;
  logic [63:0] paddr;
  logic        hit;

  modport source (output valid, req_type, set_index, way, pc, paddr, hit, input ready);
  modport sink   (input valid, req_type, set_index, way, pc, paddr, hit, output ready);
endinterface

@@ rtl/drs_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drs_out_if
// Result channel: valid/ready handshake with the decision item.
// ----------------------------------------------------------------------------
interface drs_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] victim_way;
  logic [1:0] insert_level;
  logic       stream_seen;

  modport source (output valid, victim_way, insert_level, stream_seen, input ready);
  modport sink   (input valid, victim_way, insert_level, stream_seen, output ready);
endinterface

@@ rtl/drs_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drs_front
// Accepts request items, hashes the pc and classifies the set for duelling.
// ----------------------------------------------------------------------------
module drs_front
  import drs_pkg::*;
#(
  parameter int NUM_SETS       = 2048,
  parameter int LEADER_SPACING = 32
) (
  drs_in_if.sink     in_ch,
  input  logic       q_full,
  input  logic       clearing,
  output logic       q_push,
  output drs_entry_t q_entry
);

  localparam logic [10:0] SET_MASK  = 11'(NUM_SETS - 1);
  localparam logic [10:0] LEAD_MASK = 11'(LEADER_SPACING - 1);
  localparam logic [10:0] LEAD_HALF = 11'(LEADER_SPACING / 2);

  logic [63:0] h64;
  logic [10:0] set_m;
  logic [10:0] lead_m;

  assign in_ch.ready = !q_full && !clearing;
  assign q_push      = in_ch.valid && in_ch.ready;

  assign h64    = in_ch.pc ^ (in_ch.pc >> 13) ^ (in_ch.pc >> 23);
  assign set_m  = in_ch.set_index & SET_MASK;
  assign lead_m = set_m & LEAD_MASK;

  always_comb begin
    q_entry.req_type  = in_ch.req_type;
    q_entry.set_index = set_m;
    q_entry.way       = in_ch.way;
    q_entry.hash      = h64[HASH_W-1:0];
    q_entry.blk       = in_ch.paddr[37:6];
    q_entry.hit       = in_ch.hit;
    if (lead_m == 11'd0) begin
      q_entry.lead = LEAD_SRRIP;
    end else if (lead_m == LEAD_HALF) begin
      q_entry.lead = LEAD_BRRIP;
    end else begin
      q_entry.lead = LEAD_NONE;
    end
  end

endmodule

@@ rtl/drs_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drs_queue
// Two-entry queue between the classifying front and the executing back.
// ----------------------------------------------------------------------------
module drs_queue
  import drs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  drs_entry_t push_entry,
  input  logic       pop,
  output logic       full,
  output logic       valid,
  output drs_entry_t head
);

  drs_entry_t ent_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic       do_push;
  logic       do_pop;

  assign full    = cnt_r == 2'd2;
  assign valid   = cnt_r != 2'd0;
  assign head    = ent_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= !wp_r;
      if (do_pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) ent_r[wp_r] <= push_entry;
  end

endmodule

@@ rtl/drs_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drs_back
// Reads the set row and table entries, updates them and issues the result.
// ----------------------------------------------------------------------------
module drs_back
  import drs_pkg::*;
#(
  parameter int NUM_SETS       = 2048,
  parameter int NUM_WAYS       = 16,
  parameter int SIG_ENTRIES    = 4096,
  parameter int STREAM_ENTRIES = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  drs_cfg_t   cfg,
  input  logic       q_valid,
  input  drs_entry_t q_head,
  output logic       q_pop,
  output logic       clearing,
  drs_out_if.source  out_ch
);

  localparam int SET_W   = $clog2(NUM_SETS);
  localparam int WAY_W   = $clog2(NUM_WAYS);
  localparam int SIG_W   = $clog2(SIG_ENTRIES);
  localparam int STR_W   = $clog2(STREAM_ENTRIES);
  localparam int ROW_W   = 2 * NUM_WAYS;
  localparam int STE_W   = 66;
  localparam int CLR_A   = (NUM_SETS > SIG_ENTRIES) ? NUM_SETS : SIG_ENTRIES;
  localparam int CLR_DEPTH = (CLR_A > STREAM_ENTRIES) ? CLR_A : STREAM_ENTRIES;
  localparam int CLR_W   = $clog2(CLR_DEPTH);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CLR_W-1:0] clr_r;
  logic [9:0]       sel_r, sel_nxt;
  drs_entry_t       cur_r;

  logic [ROW_W-1:0] rrpv_mem [NUM_SETS];
  logic [2:0]       sig_mem  [SIG_ENTRIES];
  logic [STE_W-1:0] str_mem  [STREAM_ENTRIES];
  logic [ROW_W-1:0] row_rd_r;
  logic [2:0]       sig_rd_r;
  logic [STE_W-1:0] str_rd_r;

  logic             rd_en;
  logic             fire;
  logic             clr_done;
  logic             row_we, sig_we, str_we;
  logic [SET_W-1:0] row_wa;
  logic [SIG_W-1:0] sig_wa;
  logic [STR_W-1:0] str_wa;
  logic [ROW_W-1:0] row_wd;
  logic [2:0]       sig_wd;
  logic [STE_W-1:0] str_wd;

  logic [NUM_WAYS-1:0][1:0] row, aged, upd_row;
  logic             any3, any2, any1;
  logic [1:0]       top;
  logic [WAY_W-1:0] vic;
  logic             way_ok;
  logic [31:0]      lb, ls, stride, ls_n;
  logic [1:0]       cf, cf_n;
  logic             streaming;
  logic [2:0]       sig_n;
  logic [1:0]       level;
  logic [3:0]       res_way;
  logic [1:0]       res_level;
  logic             res_stream;

  logic             out_valid_r;
  logic [3:0]       out_way_r;
  logic [1:0]       out_level_r;
  logic             out_stream_r;

  assign clearing = state_r == ST_CLEAR;
  assign rd_en    = (state_r == ST_IDLE) && q_valid;
  assign q_pop    = rd_en;
  assign fire     = (state_r == ST_EXEC) && (!out_valid_r || out_ch.ready);
  assign clr_done = clr_r == CLR_W'(CLR_DEPTH - 1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_done) state_nxt = ST_IDLE;
      ST_IDLE:  if (rd_en) state_nxt = ST_EXEC;
      ST_EXEC:  if (fire) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // victim search and aging of the set row
  always_comb begin
    row  = row_rd_r;
    any3 = 1'b0;
    any2 = 1'b0;
    any1 = 1'b0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      any3 = any3 | (row[w] == 2'd3);
      any2 = any2 | (row[w] == 2'd2);
      any1 = any1 | (row[w] == 2'd1);
    end
    top = any3 ? 2'd3 : (any2 ? 2'd2 : (any1 ? 2'd1 : 2'd0));
    vic = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (row[w] == top) vic = WAY_W'(w);
    end
    for (int w = 0; w < NUM_WAYS; w++) begin
      aged[w] = row[w] + (RRPV_MAX - top);
    end
  end

  // stream detector training
  always_comb begin
    lb     = str_rd_r[65:34];
    ls     = str_rd_r[33:2];
    cf     = str_rd_r[1:0];
    stride = cur_r.blk - lb;
    if (stride == ls) begin
      ls_n = ls;
      cf_n = (cf == CONF_MAX) ? cf : cf + 2'd1;
    end else begin
      ls_n = stride;
      cf_n = (cf == 2'd0) ? cf : cf - 2'd1;
    end
    streaming = cf_n == CONF_MAX;
  end

  // signature, duel selector and insertion level
  always_comb begin
    sig_n   = sig_rd_r;
    sel_nxt = sel_r;
    level   = RRPV_NEAR;
    if (cur_r.hit) begin
      if (sig_rd_r != SIG_MAX) sig_n = sig_rd_r + 3'd1;
    end else begin
      if (cur_r.lead == LEAD_SRRIP && sel_r != 10'd0) sel_nxt = sel_r - 10'd1;
      if (cur_r.lead == LEAD_BRRIP && sel_r != SEL_MAX) sel_nxt = sel_r + 10'd1;
      if (sig_rd_r >= cfg.hot_threshold) begin
        level = RRPV_NEAR;
      end else if (streaming) begin
        level = RRPV_MAX;
      end else if (sel_nxt < cfg.duel_threshold) begin
        level = RRPV_SRRIP;
      end else begin
        level = (cur_r.hash[BIMODAL_W-1:0] == '0) ? RRPV_SRRIP : RRPV_MAX;
      end
    end
    way_ok  = 6'(cur_r.way) < 6'(NUM_WAYS);
    upd_row = row;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (6'(w) == 6'(cur_r.way)) upd_row[w] = level;
    end
  end

  always_comb begin
    if (cur_r.req_type == REQ_VICTIM) begin
      res_way    = 4'(vic);
      res_level  = RRPV_NEAR;
      res_stream = 1'b0;
    end else begin
      res_way    = cur_r.way;
      res_level  = level;
      res_stream = streaming;
    end
  end

  // write ports: clearing sweep after reset, else the update of the item
  always_comb begin
    if (clearing) begin
      row_we = {1'b0, clr_r} < (CLR_W + 1)'(NUM_SETS);
      sig_we = {1'b0, clr_r} < (CLR_W + 1)'(SIG_ENTRIES);
      str_we = {1'b0, clr_r} < (CLR_W + 1)'(STREAM_ENTRIES);
      row_wa = SET_W'(clr_r);
      sig_wa = SIG_W'(clr_r);
      str_wa = STR_W'(clr_r);
      row_wd = {NUM_WAYS{RRPV_MAX}};
      sig_wd = SIG_RESET;
      str_wd = '0;
    end else begin
      row_we = fire && ((cur_r.req_type == REQ_VICTIM) || way_ok);
      sig_we = fire && (cur_r.req_type == REQ_UPDATE);
      str_we = sig_we;
      row_wa = SET_W'(cur_r.set_index);
      sig_wa = cur_r.hash[SIG_W-1:0];
      str_wa = cur_r.hash[STR_W-1:0];
      row_wd = (cur_r.req_type == REQ_VICTIM) ? aged : upd_row;
      sig_wd = sig_n;
      str_wd = {cur_r.blk, ls_n, cf_n};
    end
  end

  always_ff @(posedge clk) begin
    if (row_we) rrpv_mem[row_wa] <= row_wd;
    if (rd_en)  row_rd_r <= rrpv_mem[SET_W'(q_head.set_index)];
  end

  always_ff @(posedge clk) begin
    if (sig_we) sig_mem[sig_wa] <= sig_wd;
    if (rd_en)  sig_rd_r <= sig_mem[q_head.hash[SIG_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (str_we) str_mem[str_wa] <= str_wd;
    if (rd_en)  str_rd_r <= str_mem[q_head.hash[STR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      sel_r       <= SEL_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clearing) clr_r <= clr_r + CLR_W'(1);
      if (fire && cur_r.req_type == REQ_UPDATE) sel_r <= sel_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) cur_r <= q_head;
    if (fire) begin
      out_way_r    <= res_way;
      out_level_r  <= res_level;
      out_stream_r <= res_stream;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.victim_way   = out_way_r;
  assign out_ch.insert_level = out_level_r;
  assign out_ch.stream_seen  = out_stream_r;

endmodule

@@ rtl/drrip_ship_stream_replacement.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drrip_ship_stream_replacement
// DRRIP replacement policy with signature and stream-based insertion.
// ----------------------------------------------------------------------------
// In the back end an item first reads the set row, the signature counter and
// the stream entry from their memories, then updates the row (and, for an
// update request, the counter and the stream entry) and registers the result
// once the result register is free; no new item starts before that. After
// reset a clearing pass over max(NUM_SETS, SIG_ENTRIES, STREAM_ENTRIES)
// addresses (4096 by default) initialises the memories; no item is accepted
// meanwhile, configuration writes are. NUM_SETS, SIG_ENTRIES, STREAM_ENTRIES and
// LEADER_SPACING must be powers of two; the block itself does not enforce this.
module drrip_ship_stream_replacement
  import drs_pkg::*;
#(
  parameter int NUM_SETS       = 2048,
  parameter int NUM_WAYS       = 16,
  parameter int SIG_ENTRIES    = 4096,
  parameter int STREAM_ENTRIES = 256,
  parameter int LEADER_SPACING = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  drs_in_if.sink      in_ch,
  drs_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [2:0] hot_r;
  logic [9:0] duel_r;
  logic       cfg_we;
  drs_cfg_t   cfg;

  logic       q_push, q_full, q_valid, q_pop, clearing;
  drs_entry_t q_entry, q_head;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hot_r  <= HOT_RESET;
      duel_r <= DUEL_RESET;
    end else if (cfg_we) begin
      if (paddr[2] == REG_HOT)  hot_r  <= pwdata[2:0];
      if (paddr[2] == REG_DUEL) duel_r <= pwdata[9:0];
    end
  end

  assign prdata = (paddr[2] == REG_HOT) ? {29'd0, hot_r} : {22'd0, duel_r};

  assign cfg.hot_threshold  = hot_r;
  assign cfg.duel_threshold = duel_r;

  drs_front #(
    .NUM_SETS      (NUM_SETS),
    .LEADER_SPACING(LEADER_SPACING)
  ) u_front (
    .in_ch   (in_ch),
    .q_full  (q_full),
    .clearing(clearing),
    .q_push  (q_push),
    .q_entry (q_entry)
  );

  drs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_entry(q_entry),
    .pop       (q_pop),
    .full      (q_full),
    .valid     (q_valid),
    .head      (q_head)
  );

  drs_back #(
    .NUM_SETS      (NUM_SETS),
    .NUM_WAYS      (NUM_WAYS),
    .SIG_ENTRIES   (SIG_ENTRIES),
    .STREAM_ENTRIES(STREAM_ENTRIES)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .clearing(clearing),
    .out_ch  (out_ch)
  );

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |-> !clearing)
    else $error("item accepted during clearing pass");

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !out_ch.valid)
    else $error("result shown during clearing pass");

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("queue overflow");

  a_pop_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

endmodule

@@ tb/sv/drs_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drs_checker
// Watches the request, result and register ports of the replacement block.
// It keeps its own copy of the set rows, signature and stream tables, works
// out the decision for every accepted request and compares it with the
// results in order.
// ----------------------------------------------------------------------------
module drs_checker
  import drs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  drs_in_if           in_ch,
  drs_out_if          out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending,
  output int          n_checked,
  output int          n_streaming,
  output int          n_hot
);

  localparam logic [2:0] ADDR_HOT  = {REG_HOT, 2'b00};
  localparam logic [2:0] ADDR_DUEL = {REG_DUEL, 2'b00};

  typedef struct packed {
    logic [3:0] victim_way;
    logic [1:0] insert_level;
    logic       stream_seen;
  } decision_t;

  logic [1:0]  rrpv      [2048][16];
  logic [2:0]  sig_ctr   [4096];
  logic [31:0] last_blk  [256];
  logic [31:0] last_strd [256];
  logic [1:0]  conf      [256];
  logic [9:0]  selector;
  logic [2:0]  hot_thr;
  logic [9:0]  duel_thr;

  decision_t decisions_due[$];

  function automatic decision_t decide(logic rt, logic [10:0] set, logic [3:0] way,
                                       logic [63:0] pc, logic [63:0] pa, logic hit);
    decision_t   d;
    logic [63:0] h;
    logic [31:0] blk, strd;
    logic [1:0]  top, lvl;
    logic [4:0]  lead;
    logic        strm;
    d = '0;
    if (rt == REQ_VICTIM) begin
      top = 2'd0;
      for (int w = 0; w < 16; w++) if (rrpv[set][w] > top) top = rrpv[set][w];
      for (int w = 0; w < 16; w++) rrpv[set][w] = rrpv[set][w] + (RRPV_MAX - top);
      for (int w = 15; w >= 0; w--) if (rrpv[set][w] == RRPV_MAX) d.victim_way = 4'(w);
      return d;
    end
    h = pc ^ (pc >> 13) ^ (pc >> 23);
    blk = pa[37:6];
    strd = blk - last_blk[h[7:0]];
    if (strd == last_strd[h[7:0]]) begin
      if (conf[h[7:0]] < CONF_MAX) conf[h[7:0]]++;
    end else begin
      if (conf[h[7:0]] > 0) conf[h[7:0]]--;
      last_strd[h[7:0]] = strd;
    end
    last_blk[h[7:0]] = blk;
    strm = (conf[h[7:0]] == CONF_MAX);
    if (hit) begin
      lvl = RRPV_NEAR;
      if (sig_ctr[h[11:0]] < SIG_MAX) sig_ctr[h[11:0]]++;
    end else begin
      lead = set[4:0];
      if (lead == 5'd0) begin
        if (selector > 0) selector--;
      end else if (lead == 5'd16) begin
        if (selector < SEL_MAX) selector++;
      end
      if (sig_ctr[h[11:0]] >= hot_thr) begin
        lvl = RRPV_NEAR;
        n_hot++;
      end else if (strm) lvl = RRPV_MAX;
      else if (selector < duel_thr) lvl = RRPV_SRRIP;
      else lvl = (h[4:0] == 5'd0) ? RRPV_SRRIP : RRPV_MAX;
    end
    rrpv[set][way] = lvl;
    if (strm) n_streaming++;
    d.victim_way = way;
    d.insert_level = lvl;
    d.stream_seen = strm;
    return d;
  endfunction

  always @(posedge clk) begin
    decision_t want;
    if (!rst_n) begin
      for (int s = 0; s < 2048; s++) for (int w = 0; w < 16; w++) rrpv[s][w] = RRPV_MAX;
      for (int i = 0; i < 4096; i++) sig_ctr[i] = SIG_RESET;
      for (int i = 0; i < 256; i++) begin
        last_blk[i] = '0;
        last_strd[i] = '0;
        conf[i] = '0;
      end
      selector = SEL_RESET;
      hot_thr = HOT_RESET;
      duel_thr = DUEL_RESET;
      decisions_due.delete();
      fail_count = 0;
      n_checked = 0;
      n_streaming = 0;
      n_hot = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == ADDR_HOT) hot_thr = pwdata[2:0];
        else if (paddr == ADDR_DUEL) duel_thr = pwdata[9:0];
      end
      if (in_ch.valid && in_ch.ready)
        decisions_due.push_back(decide(in_ch.req_type, in_ch.set_index, in_ch.way,
                                       in_ch.pc, in_ch.paddr, in_ch.hit));
      if (out_ch.valid && out_ch.ready) begin
        if (decisions_due.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          want = decisions_due.pop_front();
          n_checked++;
          if (out_ch.victim_way !== want.victim_way) begin
            $error("victim_way: expected %0d, got %0d", want.victim_way, out_ch.victim_way);
            fail_count++;
          end
          if (out_ch.insert_level !== want.insert_level) begin
            $error("insert_level: expected %0d, got %0d", want.insert_level,
                   out_ch.insert_level);
            fail_count++;
          end
          if (out_ch.stream_seen !== want.stream_seen) begin
            $error("stream_seen: expected %0d, got %0d", want.stream_seen,
                   out_ch.stream_seen);
            fail_count++;
          end
        end
      end
    end
    pending = decisions_due.size();
  end

endmodule

@@ tb/sv/tb_drrip_ship_stream_replacement.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_drrip_ship_stream_replacement
// Drives directed and random cache requests and threshold settings into the
// replacement block; the checker beside it predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_drrip_ship_stream_replacement;
  import drs_pkg::*;

  localparam logic [2:0] ADDR_HOT  = {REG_HOT, 2'b00};
  localparam logic [2:0] ADDR_DUEL = {REG_DUEL, 2'b00};
  localparam int LIMIT = 600000;

  logic        clk;
  logic        rst_n;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count, pending, n_checked, n_streaming, n_hot;
  int          results_seen;

  drs_in_if  in_ch ();
  drs_out_if out_ch ();

  drrip_ship_stream_replacement dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  drs_checker chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready), .fail_count(fail_count), .pending(pending),
    .n_checked(n_checked), .n_streaming(n_streaming), .n_hot(n_hot)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("tb_drrip_ship_stream_replacement: FAIL");
        $finish;
      end
    end
  end

  // receiver: random stalls, quiet stretches, one long hold-off
  initial begin
    int hold;
    bit held_long;
    out_ch.ready = 1'b0;
    results_seen = 0;
    held_long = 0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) results_seen++;
      @(negedge clk);
      if (!held_long && results_seen >= 500) begin
        held_long = 1;
        hold = 300;
      end
      if (hold > 0) begin
        hold--;
        out_ch.ready = 1'b0;
      end else if ((results_seen / 64) % 3 == 1) begin
        out_ch.ready = 1'b1;
      end else begin
        out_ch.ready = ($urandom_range(0, 3) != 0);
      end
    end
  end

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = addr;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send(logic rt, logic [10:0] set, logic [3:0] way, logic [63:0] pc,
                      logic [63:0] pa, logic hit);
    in_ch.valid = 1'b1;
    in_ch.req_type = rt;
    in_ch.set_index = set;
    in_ch.way = way;
    in_ch.pc = pc;
    in_ch.paddr = pa;
    in_ch.hit = hit;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic idle_cycles(int n);
    in_ch.valid = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  logic [63:0] pc_pool [8];
  logic [63:0] next_pa [8];
  logic [63:0] strides [8];
  logic [10:0] set_pool [8];

  task automatic random_items(int n);
    int burst, k, r;
    burst = $urandom_range(1, 24);
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 7);
      r = $urandom_range(0, 99);
      if (r < 25) begin
        send(REQ_VICTIM, set_pool[k], 4'($urandom), {$urandom, $urandom},
             {$urandom, $urandom}, 1'($urandom));
      end else if (r < 85) begin
        if ($urandom_range(0, 9) < 7) next_pa[k] = next_pa[k] + strides[k];
        else next_pa[k] = {$urandom, $urandom};
        send(REQ_UPDATE, set_pool[$urandom_range(0, 7)], 4'($urandom), pc_pool[k],
             next_pa[k], $urandom_range(0, 2) == 0);
      end else begin
        send(1'($urandom), 11'($urandom), 4'($urandom), {$urandom, $urandom},
             {$urandom, $urandom}, 1'($urandom));
      end
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 6));
      end
    end
  endtask

  initial begin
    logic [63:0] pa;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_VICTIM;
    in_ch.set_index = '0;
    in_ch.way = '0;
    in_ch.pc = '0;
    in_ch.paddr = '0;
    in_ch.hit = 1'b0;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < 8; i++) begin
      pc_pool[i] = {$urandom, $urandom};
      next_pa[i] = {$urandom, $urandom};
      strides[i] = 64'(64 * $urandom_range(1, 8));
      if ($urandom_range(0, 1) != 0) strides[i] = -strides[i];
    end
    set_pool = '{11'd0, 11'd16, 11'd32, 11'd2047, 11'd48, 11'd5, 11'd1040, 11'd777};

    // directed: victim on a fresh set, extremes of fields, leader sets
    send(REQ_VICTIM, 11'd0, 4'd0, '0, '0, 1'b0);
    send(REQ_UPDATE, 11'd2047, 4'd15, '1, '1, 1'b1);
    send(REQ_UPDATE, 11'd2047, 4'd0, '0, '0, 1'b0);
    send(REQ_VICTIM, 11'd2047, 4'd15, '1, '1, 1'b1);
    send(REQ_UPDATE, 11'd0, 4'd3, 64'h1234, 64'h40, 1'b0);
    send(REQ_UPDATE, 11'd16, 4'd7, 64'h1234, 64'h80, 1'b0);
    send(REQ_VICTIM, 11'd0, 4'd0, '0, '0, 1'b0);
    // stride stream on one pc until it is judged streaming
    pa = 64'h0000_0010_0000_0000;
    for (int i = 0; i < 6; i++) begin
      send(REQ_UPDATE, 11'd5, i[3:0], 64'hdead_beef_0000_0040, pa, 1'b0);
      pa = pa + 64'h100;
    end
    // repeated hits make a signature hot, then a miss on it
    for (int i = 0; i < 4; i++) send(REQ_UPDATE, 11'd9, 4'd2, 64'h77, {$urandom, $urandom}, 1'b1);
    send(REQ_UPDATE, 11'd9, 4'd2, 64'h77, {$urandom, $urandom}, 1'b0);
    send(REQ_VICTIM, 11'd9, 4'd0, '0, '0, 1'b0);
    drain();

    reg_write(ADDR_HOT, 32'd0);
    reg_write(ADDR_DUEL, 32'd0);
    random_items(350);
    drain();
    reg_write(ADDR_HOT, 32'd7);
    reg_write(ADDR_DUEL, 32'd1023);
    random_items(450);
    drain();
    reg_write(ADDR_HOT, 32'd5);
    reg_write(ADDR_DUEL, 32'd511);
    random_items(400);
    drain();
    reg_write(ADDR_HOT, $urandom_range(1, 6));
    reg_write(ADDR_DUEL, $urandom_range(400, 620));
    random_items(400);
    drain();

    $display("checked %0d results: %0d streaming updates, %0d hot-signature misses",
             n_checked, n_streaming, n_hot);
    if (fail_count == 0) begin
      $display("tb_drrip_ship_stream_replacement: PASS");
    end else begin
      $display("tb_drrip_ship_stream_replacement: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/drs_pkg.sv
rtl/drs_in_if.sv
rtl/drs_out_if.sv
rtl/drs_front.sv
rtl/drs_queue.sv
rtl/drs_back.sv
rtl/drrip_ship_stream_replacement.sv
tb/sv/drs_checker.sv
tb/sv/tb_drrip_ship_stream_replacement.sv
